// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is held.
`define PLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("positional list check failed");

// Implication check: the consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list sequencing check failed");

`endif

// ===== src/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

  // Default build values for the list storage.
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ENTRY_W_DEF = 32;

  // Fixed field widths of the request and result transactions.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FOUND_W = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_FIND   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_FETCH_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== src/ple_store.sv =====
`default_nettype none

// Entry storage: one write port and one read port with registered read data.
module ple_store #(
  parameter int unsigned DEPTH       = ple_pkg::DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = ple_pkg::ENTRY_W_DEF,
  localparam int unsigned AW         = $clog2(DEPTH)
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [ENTRY_WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]          raddr_i,
  output logic      [ENTRY_WIDTH-1:0] rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/positional_list_engine_top.sv =====
// Positional list engine: an ordered list of up to DEPTH entries.
// Request channel: req_type_i, position_i and value_i are taken as one
// transaction at a rising edge where start_i is high and busy_o is low.
// Request kinds are insert at a position, remove at a position, read at a
// position and find the first position that holds a value.
// Result channel: done_o is high for exactly one cycle, and status_o, data_o,
// found_index_o, count_o and empty_res_o hold the result in that cycle.
// The receiver cannot hold a result off; busy_o stays high through done_o.
// Each request is worked by the sequencer: the entry store has one read port
// with registered data and one write port, and each shifted entry takes a
// read step and then a write step; a find compares one entry at a time
// through one shared comparator. One request is in flight at a time; the
// next can be taken in the cycle after done_o.
// Reset empties the list at once; entry contents are not cleared.
`default_nettype none

module positional_list_engine_top #(
  parameter int unsigned DEPTH       = ple_pkg::DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = ple_pkg::ENTRY_W_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ple_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [ple_pkg::POS_W-1:0]     position_i,
  input  wire logic [ple_pkg::VAL_W-1:0]     value_i,
  output logic                               done_o,
  output logic      [ple_pkg::STAT_W-1:0]    status_o,
  output logic      [ple_pkg::VAL_W-1:0]     data_o,
  output logic      [ple_pkg::FOUND_W-1:0]   found_index_o,
  output logic      [ple_pkg::COUNT_W-1:0]   count_o,
  output logic                               empty_res_o
);

`include "assert_macros.svh"

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

  ple_pkg::state_e  state_q, state_d;
  ple_pkg::req_e    op_q, op_d;
  ple_pkg::status_e status_q, status_d;

  logic [CW-1:0]                 occ_q, occ_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 pos_q, pos_d;
  logic [ENTRY_WIDTH-1:0]        val_q, val_d;
  logic [ple_pkg::VAL_W-1:0]     data_q, data_d;
  logic [ple_pkg::FOUND_W-1:0]   found_q, found_d;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ENTRY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  logic [ENTRY_WIDTH-1:0]    val_in;
  logic [ple_pkg::VAL_W-1:0] rd_wide;
  logic [CW-1:0]             idx_step;
  logic                      shift_up;
  logic                      shift_more;
  logic                      entry_hit;
  logic                      accept;
  logic                      ins_range;
  logic                      acc_range;
  logic                      list_full;

  // Fit the incoming value to the entry width, and the stored entry to the data port.
  for (genvar b = 0; b < ENTRY_WIDTH; b++) begin : g_val
    if (b < ple_pkg::VAL_W) begin : g_bit
      assign val_in[b] = value_i[b];
    end else begin : g_zero
      assign val_in[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < ple_pkg::VAL_W; b++) begin : g_rd
    if (b < ENTRY_WIDTH) begin : g_bit
      assign rd_wide[b] = mem_rdata[b];
    end else begin : g_zero
      assign rd_wide[b] = 1'b0;
    end
  end

  ple_store #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Request checks against the current occupancy.
  assign accept    = start_i && (state_q == ple_pkg::S_IDLE);
  assign ins_range = CMPW'(position_i) > CMPW'(occ_q);
  assign acc_range = CMPW'(position_i) >= CMPW'(occ_q);
  assign list_full = occ_q == CW'(DEPTH);

  // Shared index stepper: inserts walk down from the tail, everything else walks up.
  assign shift_up   = op_q == ple_pkg::REQ_INSERT;
  assign idx_step   = shift_up ? (idx_q - CW'(1)) : (idx_q + CW'(1));
  assign shift_more = shift_up ? (idx_q > pos_q) : (idx_step < occ_q);
  assign entry_hit  = mem_rdata == val_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (ple_pkg::req_e'(req_type_i))
            ple_pkg::REQ_INSERT: begin
              state_d = (ins_range || list_full) ? ple_pkg::S_DONE : ple_pkg::S_SHIFT_RD;
            end
            ple_pkg::REQ_REMOVE,
            ple_pkg::REQ_READ: begin
              state_d = acc_range ? ple_pkg::S_DONE : ple_pkg::S_FETCH;
            end
            ple_pkg::REQ_FIND: begin
              state_d = ple_pkg::S_FIND_RD;
            end
            default: state_d = ple_pkg::S_IDLE;
          endcase
        end
      end
      ple_pkg::S_FETCH:      state_d = ple_pkg::S_FETCH_WAIT;
      ple_pkg::S_FETCH_WAIT: begin
        state_d = (op_q == ple_pkg::REQ_READ) ? ple_pkg::S_DONE : ple_pkg::S_SHIFT_RD;
      end
      ple_pkg::S_SHIFT_RD: begin
        priority if (shift_more) begin
          state_d = ple_pkg::S_SHIFT_WR;
        end else if (shift_up) begin
          state_d = ple_pkg::S_INS_WR;
        end else begin
          state_d = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_SHIFT_WR:   state_d = ple_pkg::S_SHIFT_RD;
      ple_pkg::S_INS_WR:     state_d = ple_pkg::S_DONE;
      ple_pkg::S_FIND_RD: begin
        state_d = (idx_q < occ_q) ? ple_pkg::S_FIND_CMP : ple_pkg::S_DONE;
      end
      ple_pkg::S_FIND_CMP: begin
        state_d = entry_hit ? ple_pkg::S_DONE : ple_pkg::S_FIND_RD;
      end
      ple_pkg::S_DONE:       state_d = ple_pkg::S_IDLE;
      default:               state_d = ple_pkg::S_IDLE;
    endcase
  end

  // Datapath and store control for each sequencer step.
  always_comb begin
    op_d      = op_q;
    status_d  = status_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    data_d    = data_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_q[AW-1:0];

    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = ple_pkg::req_e'(req_type_i);
          pos_d    = CW'(position_i);
          val_d    = val_in;
          data_d   = '0;
          found_d  = '0;
          status_d = ple_pkg::ST_OK;
          idx_d    = CW'(position_i);
          unique case (ple_pkg::req_e'(req_type_i))
            ple_pkg::REQ_INSERT: begin
              idx_d = occ_q;
              priority if (ins_range) begin
                status_d = ple_pkg::ST_RANGE;
              end else if (list_full) begin
                status_d = ple_pkg::ST_FULL;
              end
            end
            ple_pkg::REQ_REMOVE,
            ple_pkg::REQ_READ: begin
              if (acc_range) begin
                status_d = ple_pkg::ST_RANGE;
              end
            end
            ple_pkg::REQ_FIND: begin
              idx_d = '0;
            end
            default: status_d = ple_pkg::ST_OK;
          endcase
        end
      end
      ple_pkg::S_FETCH: begin
        mem_raddr = idx_q[AW-1:0];
      end
      ple_pkg::S_FETCH_WAIT: begin
        data_d = rd_wide;
      end
      ple_pkg::S_SHIFT_RD: begin
        // Fetch the neighbor that moves into the current slot.
        mem_raddr = idx_step[AW-1:0];
        if (!shift_more && !shift_up) begin
          occ_d = occ_q - CW'(1);
        end
      end
      ple_pkg::S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = mem_rdata;
        idx_d     = idx_step;
      end
      ple_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = val_q;
        occ_d     = occ_q + CW'(1);
      end
      ple_pkg::S_FIND_RD: begin
        mem_raddr = idx_q[AW-1:0];
        if (idx_q >= occ_q) begin
          status_d = ple_pkg::ST_NOTFOUND;
        end
      end
      ple_pkg::S_FIND_CMP: begin
        if (entry_hit) begin
          found_d = ple_pkg::FOUND_W'(idx_q);
        end else begin
          idx_d = idx_step;
        end
      end
      ple_pkg::S_DONE: begin
        mem_we = 1'b0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    data_q   <= data_d;
    found_q  <= found_d;
  end

  // Result transaction.
  assign busy_o        = state_q != ple_pkg::S_IDLE;
  assign done_o        = state_q == ple_pkg::S_DONE;
  assign status_o      = status_q;
  assign data_o        = data_q;
  assign found_index_o = found_q;
  assign count_o       = ple_pkg::COUNT_W'(occ_q);
  assign empty_res_o   = occ_q == '0;

  // Occupancy never goes past the capacity.
  `PLE_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= CW'(DEPTH))
  // The list size only moves while a request is being worked on.
  `PLE_ASSERT_NEXT(a_occ_idle, clk_i, rst_ni, !busy_o, $stable(occ_q))
  // A full report means the list really is at capacity.
  `PLE_ASSERT(a_full_cnt, clk_i, rst_ni, !(done_o && status_o == ple_pkg::ST_FULL) || list_full)
  // A failed request returns no data and no index.
  `PLE_ASSERT(a_err_zero, clk_i, rst_ni, !(done_o && status_o != ple_pkg::ST_OK) || (data_o == '0 && found_index_o == '0))

endmodule

`default_nettype wire
